// ----- design/arpc_pkg.sv -----
// Shared types and constants for the ARP cache and responder.
// Used by arpc_table, arpc_engine and arp_cache_and_responder_unit.
package arpc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  // Item kinds
  localparam logic [1:0] KIND_RX      = 2'd0;
  localparam logic [1:0] KIND_RESOLVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  // ARP header codes
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PTYPE_IP4   = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;

  // Frame opcodes on the result side
  localparam logic [1:0] FRAME_OP_NONE    = 2'd0;
  localparam logic [1:0] FRAME_OP_REQUEST = 2'd1;
  localparam logic [1:0] FRAME_OP_REPLY   = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_PROTO = 2'd1;
  localparam logic [1:0] STATUS_BAD_HW    = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arpc_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [1:0]  frame_opcode;
    logic [47:0] frame_dest_mac;
    logic [31:0] frame_target_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    logic        lookup_pending;
    logic        entry_changed;
    logic        neighbor_resolved;
    logic [1:0]  status;
  } arpc_result_t;

  // One table slot as read back
  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        pending;
  } arpc_rd_t;

  // Write request into the table; a write always marks the slot valid
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        pending;
  } arpc_wr_t;

endpackage

// ----- design/arp_cache_and_responder_unit.sv -----
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    kind, hw_type, proto_type, opcode,
//                                       sender_mac, sender_ip, target_ip
// out       out  out_valid / out_stall  frame_*, lookup_*, entry_changed,
//                                       neighbor_resolved, status
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A table item goes from accept through the SCAN and UPDATE states to HOLD
// and then the output register; the scan reads one slot a cycle through a
// single read port and one IP comparator. Received packets with a non-IPv4 protocol
// and unused kinds skip the scan. Reset (rst, synchronous) clears all slots.
// in_stall stays high while an item is in work or its result waits for the
// output register; the output register frees itself while out_stall is low.
// Top level of the ARP cache and responder. Depends on arpc_pkg, arpc_table
// and arpc_engine.
module arp_cache_and_responder_unit #(
  parameter int unsigned TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] hw_type,
  input  logic [15:0] proto_type,
  input  logic [15:0] opcode,
  input  logic [47:0] sender_mac,
  input  logic [31:0] sender_ip,
  input  logic [31:0] target_ip,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_valid,
  output logic [1:0]  frame_opcode,
  output logic [47:0] frame_dest_mac,
  output logic [31:0] frame_target_ip,
  output logic        lookup_hit,
  output logic [47:0] lookup_mac,
  output logic        lookup_pending,
  output logic        entry_changed,
  output logic        neighbor_resolved,
  output logic [1:0]  status,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [31:0]            own_ip;
  arpc_pkg::arpc_item_t   item;
  arpc_pkg::arpc_rd_t     rd;
  arpc_pkg::arpc_wr_t     wr;
  arpc_pkg::arpc_result_t res;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   rd_en;
  logic                   busy;
  logic                   res_valid;
  logic                   res_taken;
  logic                   in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign res_taken = res_valid && (!out_valid || !out_stall);

  assign item.kind       = kind;
  assign item.hw_type    = hw_type;
  assign item.proto_type = proto_type;
  assign item.opcode     = opcode;
  assign item.sender_mac = sender_mac;
  assign item.sender_ip  = sender_ip;
  assign item.target_ip  = target_ip;

  // own_mac is the sender address of sent frames, inserted by the transmit
  // path; only own_ip is held here.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arpc_pkg::CFG_OWN_IP: own_ip <= cfg_data[31:0];
        default: begin
          own_ip <= own_ip;
        end
      endcase
    end
  end

  arpc_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd      (rd),
    .wr      (wr),
    .wr_addr (wr_addr)
  );

  arpc_engine #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept),
    .item      (item),
    .own_ip    (own_ip),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd        (rd),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      frame_valid       <= res.frame_valid;
      frame_opcode      <= res.frame_opcode;
      frame_dest_mac    <= res.frame_dest_mac;
      frame_target_ip   <= res.frame_target_ip;
      lookup_hit        <= res.lookup_hit;
      lookup_mac        <= res.lookup_mac;
      lookup_pending    <= res.lookup_pending;
      entry_changed     <= res.entry_changed;
      neighbor_resolved <= res.neighbor_resolved;
      status            <= res.status;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("input accepted while the engine stayed idle");

  a_frame_opcode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_valid) |->
      (frame_opcode == arpc_pkg::FRAME_OP_REQUEST ||
       frame_opcode == arpc_pkg::FRAME_OP_REPLY))
    else $error("frame sent without a request or reply opcode");

  a_pending_lookup: assert property (@(posedge clk) disable iff (rst)
    (out_valid && lookup_pending) |-> (lookup_hit && lookup_mac == '0))
    else $error("pending lookup without hit or with nonzero MAC");

  a_resolved_is_rx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && neighbor_resolved) |-> !lookup_hit)
    else $error("refresh and lookup hit reported together");

endmodule

// ----- design/arpc_table.sv -----
// ARP slot storage: IP, MAC and pending memories plus per-slot valid flops.
// One registered read port, one write port. Depends on arpc_pkg.
module arpc_table #(
  parameter int unsigned ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output arpc_pkg::arpc_rd_t rd,
  input  arpc_pkg::arpc_wr_t wr,
  input  logic [IDX_W-1:0]   wr_addr
);

  logic [31:0] mem_ip   [ENTRIES];
  logic [47:0] mem_mac  [ENTRIES];
  logic        mem_pend [ENTRIES];
  logic [ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_ip[wr_addr]   <= wr.ip;
      mem_mac[wr_addr]  <= wr.mac;
      mem_pend[wr_addr] <= wr.pending;
    end
    if (rd_en) begin
      rd.valid   <= valid[rd_addr];
      rd.ip      <= mem_ip[rd_addr];
      rd.mac     <= mem_mac[rd_addr];
      rd.pending <= mem_pend[rd_addr];
    end
  end

endmodule

// ----- design/arpc_engine.sv -----
// Sequencer for the ARP cache: scans the table one slot a cycle through a
// single IP comparator, then applies at most one table write and builds the result.
// Depends on arpc_pkg; drives arpc_table.
module arpc_engine #(
  parameter int unsigned ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  arpc_pkg::arpc_item_t   item,
  input  logic [31:0]            own_ip,
  output logic                   rd_en,
  output logic [IDX_W-1:0]       rd_addr,
  input  arpc_pkg::arpc_rd_t     rd,
  output arpc_pkg::arpc_wr_t     wr,
  output logic [IDX_W-1:0]       wr_addr,
  output logic                   busy,
  output logic                   res_valid,
  output arpc_pkg::arpc_result_t res,
  input  logic                   res_taken
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    UPDATE,
    HOLD
  } state_t;

  state_t               state;
  arpc_pkg::arpc_item_t itm;
  logic [31:0]          key;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 chk;
  logic [IDX_W-1:0]     chk_idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic [47:0]          hit_mac;
  logic                 hit_pending;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;

  arpc_pkg::arpc_result_t upd_res;
  arpc_pkg::arpc_result_t proto_res;
  arpc_pkg::arpc_wr_t     upd_wr;
  logic [IDX_W-1:0]       upd_idx;
  logic                   own_match;
  logic                   full;

  assign rd_en     = (state == SCAN) && (issue_cnt != CNT_W'(ENTRIES));
  assign rd_addr   = issue_cnt[IDX_W-1:0];
  assign busy      = (state != IDLE);
  assign res_valid = (state == HOLD);
  assign own_match = (itm.target_ip == own_ip);

  // Result for a received packet that is not IPv4
  always_comb begin
    proto_res        = '0;
    proto_res.status = arpc_pkg::STATUS_BAD_PROTO;
  end

  // Outcome of the scan: at most one slot write and the result item
  always_comb begin
    upd_res = '0;
    upd_wr  = '0;
    upd_idx = free_idx;
    full    = 1'b0;
    case (itm.kind)
      arpc_pkg::KIND_RX: begin
        if (hit_found) begin
          upd_wr.en                 = 1'b1;
          upd_wr.ip                 = key;
          upd_wr.mac                = itm.sender_mac;
          upd_wr.pending            = 1'b0;
          upd_idx                   = hit_idx;
          upd_res.entry_changed     = (hit_mac != itm.sender_mac);
          upd_res.neighbor_resolved = 1'b1;
        end else if (own_match) begin
          if (free_found) begin
            upd_wr.en      = 1'b1;
            upd_wr.ip      = itm.sender_ip;
            upd_wr.mac     = itm.sender_mac;
            upd_wr.pending = 1'b0;
          end else begin
            full = 1'b1;
          end
        end
        if ((itm.opcode == arpc_pkg::OP_REQUEST) && own_match) begin
          upd_res.frame_valid     = 1'b1;
          upd_res.frame_opcode    = arpc_pkg::FRAME_OP_REPLY;
          upd_res.frame_dest_mac  = itm.sender_mac;
          upd_res.frame_target_ip = itm.sender_ip;
        end
        if (full) begin
          upd_res.status = arpc_pkg::STATUS_FULL;
        end else if (itm.hw_type != arpc_pkg::HW_ETHERNET) begin
          upd_res.status = arpc_pkg::STATUS_BAD_HW;
        end else begin
          upd_res.status = arpc_pkg::STATUS_OK;
        end
      end
      arpc_pkg::KIND_RESOLVE: begin
        upd_res.frame_valid     = 1'b1;
        upd_res.frame_opcode    = arpc_pkg::FRAME_OP_REQUEST;
        upd_res.frame_dest_mac  = arpc_pkg::BCAST_MAC;
        upd_res.frame_target_ip = itm.target_ip;
        if (!hit_found) begin
          if (free_found) begin
            upd_wr.en      = 1'b1;
            upd_wr.ip      = itm.target_ip;
            upd_wr.mac     = '0;
            upd_wr.pending = 1'b1;
          end else begin
            upd_res.status = arpc_pkg::STATUS_FULL;
          end
        end
      end
      arpc_pkg::KIND_LOOKUP: begin
        if (hit_found) begin
          upd_res.lookup_hit     = 1'b1;
          upd_res.lookup_mac     = hit_pending ? '0 : hit_mac;
          upd_res.lookup_pending = hit_pending;
        end
      end
      default: begin
        upd_res = '0;
      end
    endcase
  end

  always_comb begin
    wr     = upd_wr;
    wr.en  = upd_wr.en && (state == UPDATE);
    wr_addr = upd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      chk        <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            itm        <= item;
            key        <= (item.kind == arpc_pkg::KIND_RX) ? item.sender_ip : item.target_ip;
            issue_cnt  <= '0;
            chk        <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            if ((item.kind == arpc_pkg::KIND_RX) &&
                (item.proto_type != arpc_pkg::PTYPE_IP4)) begin
              res   <= proto_res;
              state <= HOLD;
            end else if ((item.kind == arpc_pkg::KIND_RX) ||
                         (item.kind == arpc_pkg::KIND_RESOLVE) ||
                         (item.kind == arpc_pkg::KIND_LOOKUP)) begin
              state <= SCAN;
            end else begin
              // unused kind: empty result
              res   <= '0;
              state <= HOLD;
            end
          end
        end
        SCAN: begin
          // check the slot read in the previous cycle; keep the lowest match
          if (chk) begin
            if (rd.valid && (rd.ip == key) && !hit_found) begin
              hit_found   <= 1'b1;
              hit_idx     <= chk_idx;
              hit_mac     <= rd.mac;
              hit_pending <= rd.pending;
            end
            if (!rd.valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
          end
          if (rd_en) begin
            issue_cnt <= issue_cnt + 1'b1;
            chk       <= 1'b1;
            chk_idx   <= rd_addr;
          end else begin
            chk   <= 1'b0;
            state <= UPDATE;
          end
        end
        UPDATE: begin
          res   <= upd_res;
          state <= HOLD;
        end
        HOLD: begin
          if (res_taken) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/arp_cache_and_responder_unit_test.sv -----
// Self-checking testbench for arp_cache_and_responder_unit: directed ARP cases, then
// random packet, resolve and lookup traffic checked against an in-bench table model.
// Depends on arpc_pkg and the design sources only.
module arp_cache_and_responder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = arpc_pkg::TABLE_ENTRIES_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [15:0] OP_REPLY_CODE = 16'h0002;
  localparam int IDLE_PCT = 8;
  localparam int SETTLE_CYCLES = SLOTS + 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IP_POOL_SIZE = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = arpc_pkg::KIND_RX;
  logic [15:0] hw_type = '0;
  logic [15:0] proto_type = '0;
  logic [15:0] opcode = '0;
  logic [47:0] sender_mac = '0;
  logic [31:0] sender_ip = '0;
  logic [31:0] target_ip = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        frame_valid;
  logic [1:0]  frame_opcode;
  logic [47:0] frame_dest_mac;
  logic [31:0] frame_target_ip;
  logic        lookup_hit;
  logic [47:0] lookup_mac;
  logic        lookup_pending;
  logic        entry_changed;
  logic        neighbor_resolved;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = arpc_pkg::CFG_OWN_IP;
  logic [47:0] cfg_data = '0;

  arp_cache_and_responder_unit dut (.*);

  // Table model and interface settings
  bit          slot_used [SLOTS];
  bit [31:0]   slot_addr [SLOTS];
  bit [47:0]   slot_hw   [SLOTS];
  bit          slot_wait [SLOTS];
  logic [31:0] iface_ip = '0;
  logic [47:0] iface_mac = '0;

  arpc_pkg::arpc_result_t arp_results_due[$];
  logic [31:0]  ip_pool [IP_POOL_SIZE];
  logic [47:0]  mac_pool [4];

  bit calm = 1'b0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int frames_due = 0;
  int refreshes_due = 0;
  int full_due = 0;
  int hits_due = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               arp_results_due.size());
      $display("[arp_cache_and_responder_unit] ERROR");
      $finish;
    end
  end

  function automatic int find_slot(logic [31:0] ip);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_addr[i] == ip) return i;
    return -1;
  endfunction

  function automatic bit add_slot(logic [31:0] ip, logic [47:0] mac, bit waiting);
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_addr[i] = ip;
        slot_hw[i] = mac;
        slot_wait[i] = waiting;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one item to the table model and return the result it must produce.
  function automatic arpc_pkg::arpc_result_t predict_arp_result(arpc_pkg::arpc_item_t it);
    arpc_pkg::arpc_result_t r;
    int hit;
    bit full;
    r = '0;
    full = 1'b0;
    case (it.kind)
      arpc_pkg::KIND_RX: begin
        if (it.proto_type != arpc_pkg::PTYPE_IP4) begin
          r.status = arpc_pkg::STATUS_BAD_PROTO;
        end else begin
          hit = find_slot(it.sender_ip);
          if (hit >= 0) begin
            r.entry_changed = (slot_hw[hit] != it.sender_mac);
            r.neighbor_resolved = 1'b1;
            slot_hw[hit] = it.sender_mac;
            slot_wait[hit] = 1'b0;
          end else if (it.target_ip == iface_ip) begin
            full = !add_slot(it.sender_ip, it.sender_mac, 1'b0);
          end
          if (it.opcode == arpc_pkg::OP_REQUEST && it.target_ip == iface_ip) begin
            r.frame_valid = 1'b1;
            r.frame_opcode = arpc_pkg::FRAME_OP_REPLY;
            r.frame_dest_mac = it.sender_mac;
            r.frame_target_ip = it.sender_ip;
          end
          if (full) r.status = arpc_pkg::STATUS_FULL;
          else if (it.hw_type != arpc_pkg::HW_ETHERNET) r.status = arpc_pkg::STATUS_BAD_HW;
        end
      end
      arpc_pkg::KIND_RESOLVE: begin
        r.frame_valid = 1'b1;
        r.frame_opcode = arpc_pkg::FRAME_OP_REQUEST;
        r.frame_dest_mac = arpc_pkg::BCAST_MAC;
        r.frame_target_ip = it.target_ip;
        if (find_slot(it.target_ip) < 0 && !add_slot(it.target_ip, '0, 1'b1))
          r.status = arpc_pkg::STATUS_FULL;
      end
      arpc_pkg::KIND_LOOKUP: begin
        hit = find_slot(it.target_ip);
        if (hit >= 0) begin
          r.lookup_hit = 1'b1;
          r.lookup_pending = slot_wait[hit];
          r.lookup_mac = slot_wait[hit] ? '0 : slot_hw[hit];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic arpc_pkg::arpc_item_t arp_item(logic [1:0] k, logic [15:0] hw,
                                                    logic [15:0] pr, logic [15:0] op,
                                                    logic [47:0] smac, logic [31:0] sip,
                                                    logic [31:0] tip);
    arpc_pkg::arpc_item_t it;
    it.kind = k;
    it.hw_type = hw;
    it.proto_type = pr;
    it.opcode = op;
    it.sender_mac = smac;
    it.sender_ip = sip;
    it.target_ip = tip;
    return it;
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 99) < 85) return ip_pool[$urandom_range(0, IP_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Mostly well-formed Ethernet/IPv4 traffic around a small set of neighbors.
  function automatic arpc_pkg::arpc_item_t random_arp_item();
    arpc_pkg::arpc_item_t it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) it.kind = arpc_pkg::KIND_RX;
    else if (roll < 70) it.kind = arpc_pkg::KIND_RESOLVE;
    else if (roll < 95) it.kind = arpc_pkg::KIND_LOOKUP;
    else it.kind = KIND_UNUSED;
    it.hw_type = ($urandom_range(0, 99) < 85) ? arpc_pkg::HW_ETHERNET : 16'($urandom);
    it.proto_type = ($urandom_range(0, 99) < 85) ? arpc_pkg::PTYPE_IP4 : 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 45) it.opcode = arpc_pkg::OP_REQUEST;
    else if (roll < 85) it.opcode = OP_REPLY_CODE;
    else it.opcode = 16'($urandom);
    it.sender_mac = ($urandom_range(0, 99) < 70) ? mac_pool[$urandom_range(0, 3)]
                                                 : {16'($urandom), 32'($urandom)};
    it.sender_ip = pick_ip();
    it.target_ip = ($urandom_range(0, 99) < 40) ? iface_ip : pick_ip();
    return it;
  endfunction

  task automatic send_item(input arpc_pkg::arpc_item_t it);
    arpc_pkg::arpc_result_t want;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    hw_type <= it.hw_type;
    proto_type <= it.proto_type;
    opcode <= it.opcode;
    sender_mac <= it.sender_mac;
    sender_ip <= it.sender_ip;
    target_ip <= it.target_ip;
    do @(posedge clk); while (in_stall);
    want = predict_arp_result(it);
    arp_results_due.push_back(want);
    items_sent++;
    frames_due += int'(want.frame_valid);
    refreshes_due += int'(want.neighbor_resolved);
    hits_due += int'(want.lookup_hit);
    if (want.status == arpc_pkg::STATUS_FULL) full_due++;
  endtask

  // Drop valid, let every expected result arrive, then let the scan settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (arp_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold cfg_valid across both writes; lower it once at the end.
  task automatic write_reg(input logic idx, input logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == arpc_pkg::CFG_OWN_IP) iface_ip = data[31:0];
    else iface_mac = data;
    reg_writes++;
  endtask

  task automatic program_iface(input logic [31:0] ip, input logic [47:0] mac);
    write_reg(arpc_pkg::CFG_OWN_IP, {16'($urandom), ip});
    write_reg(arpc_pkg::CFG_OWN_MAC, mac);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    arpc_pkg::arpc_result_t want;
    if (out_valid && !out_stall) begin
      results_seen++;
      if (arp_results_due.size() == 0) begin
        $display("%0t: result with no item outstanding, expected none, actual status %h",
                 $time, status);
        mismatches++;
      end else begin
        want = arp_results_due.pop_front();
        report_field("frame_valid", 64'(want.frame_valid), 64'(frame_valid));
        report_field("frame_opcode", 64'(want.frame_opcode), 64'(frame_opcode));
        report_field("frame_dest_mac", 64'(want.frame_dest_mac), 64'(frame_dest_mac));
        report_field("frame_target_ip", 64'(want.frame_target_ip), 64'(frame_target_ip));
        report_field("lookup_hit", 64'(want.lookup_hit), 64'(lookup_hit));
        report_field("lookup_mac", 64'(want.lookup_mac), 64'(lookup_mac));
        report_field("lookup_pending", 64'(want.lookup_pending), 64'(lookup_pending));
        report_field("entry_changed", 64'(want.entry_changed), 64'(entry_changed));
        report_field("neighbor_resolved", 64'(want.neighbor_resolved),
                     64'(neighbor_resolved));
        report_field("status", 64'(want.status), 64'(status));
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Learning, refresh, reply and the rejected-packet cases on an empty table.
  task automatic test_packet_handling();
    logic [31:0] me;
    me = iface_ip;
    send_item(arp_item(arpc_pkg::KIND_LOOKUP, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, 32'h0A00_0002));
    send_item(arp_item(arpc_pkg::KIND_RX, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, 48'h0011_2233_4455, 32'h0A00_0002, me));
    send_item(arp_item(arpc_pkg::KIND_LOOKUP, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, 32'h0A00_0002));
    // changed MAC, then the same MAC again from a packet aimed elsewhere
    send_item(arp_item(arpc_pkg::KIND_RX, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       OP_REPLY_CODE, 48'h0011_2233_4466, 32'h0A00_0002, me));
    send_item(arp_item(arpc_pkg::KIND_RX, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       OP_REPLY_CODE, 48'h0011_2233_4466, 32'h0A00_0002, 32'h0A00_0004));
    send_item(arp_item(arpc_pkg::KIND_RX, arpc_pkg::HW_ETHERNET, 16'h86DD,
                       arpc_pkg::OP_REQUEST, 48'h0011_2233_4477, 32'h0A00_0003, me));
    send_item(arp_item(arpc_pkg::KIND_RX, 16'hFFFF, 16'hFFFF,
                       arpc_pkg::OP_REQUEST, 48'h0011_2233_4477, 32'h0A00_0003, me));
    send_item(arp_item(arpc_pkg::KIND_RX, 16'h0006, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, 48'h0011_2233_4477, 32'h0A00_0003, me));
    send_item(arp_item(arpc_pkg::KIND_RX, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, 48'h0011_2233_4488, 32'h0A00_0004,
                       32'h0A00_00FF));
    send_item(arp_item(arpc_pkg::KIND_LOOKUP, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, 32'h0A00_0004));
    send_item(arp_item(arpc_pkg::KIND_RX, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       16'hFFFF, '1, '1, me));
    send_item(arp_item(arpc_pkg::KIND_RX, 16'h0000, arpc_pkg::PTYPE_IP4, 16'h0000,
                       '0, '0, '0));
    send_item(arp_item(KIND_UNUSED, '1, '1, '1, '1, '1, '1));
  endtask

  // Pending slots from resolve, their lookups and their resolution.
  task automatic test_resolve_and_lookup();
    logic [31:0] me;
    me = iface_ip;
    send_item(arp_item(arpc_pkg::KIND_RESOLVE, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, 32'h0A00_0005));
    send_item(arp_item(arpc_pkg::KIND_LOOKUP, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, 32'h0A00_0005));
    send_item(arp_item(arpc_pkg::KIND_RESOLVE, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, 32'h0A00_0005));
    // a zero MAC against a pending slot is not a change
    send_item(arp_item(arpc_pkg::KIND_RX, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       OP_REPLY_CODE, '0, 32'h0A00_0005, 32'h0A00_0009));
    send_item(arp_item(arpc_pkg::KIND_LOOKUP, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, 32'h0A00_0005));
    send_item(arp_item(arpc_pkg::KIND_RESOLVE, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, 32'h0A00_0006));
    send_item(arp_item(arpc_pkg::KIND_RX, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, 48'hA0B0_C0D0_E0F0, 32'h0A00_0006, me));
    send_item(arp_item(arpc_pkg::KIND_LOOKUP, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, 32'h0A00_0006));
    send_item(arp_item(arpc_pkg::KIND_RESOLVE, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, '1));
    send_item(arp_item(arpc_pkg::KIND_LOOKUP, arpc_pkg::HW_ETHERNET, arpc_pkg::PTYPE_IP4,
                       arpc_pkg::OP_REQUEST, '0, '0, '0));
  endtask

  // Random traffic; the table fills early and stays full from then on.
  task automatic test_random_traffic(input int count, input bit no_idle);
    calm = no_idle;
    for (int n = 0; n < count; n++) begin
      send_item(random_arp_item());
      if (n % 150 == 149) wait_idle();
    end
    calm = 1'b0;
  endtask

  initial begin
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < IP_POOL_SIZE; i++) ip_pool[i] = $urandom;
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    mac_pool[2] = {16'($urandom), 32'($urandom)};
    mac_pool[3] = {16'($urandom), 32'($urandom)};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_iface(32'h0A00_0001, 48'h0200_0000_0001);
    test_packet_handling();
    test_resolve_and_lookup();
    wait_idle();

    program_iface('1, '1);
    test_random_traffic(450, 1'b0);
    wait_idle();

    program_iface('0, '0);
    test_random_traffic(300, 1'b1);
    wait_idle();

    program_iface($urandom, {16'($urandom), 32'($urandom)});
    test_random_traffic(550, 1'b0);
    wait_idle();

    $display("Sent %0d items over %0d register writes; %0d results checked", items_sent,
             reg_writes, results_seen);
    $display("Frames %0d, refreshes %0d, lookup hits %0d, table-full results %0d",
             frames_due, refreshes_due, hits_due, full_due);
    if (mismatches == 0 && arp_results_due.size() == 0) begin
      $display("[arp_cache_and_responder_unit] OK");
    end else begin
      $display("[arp_cache_and_responder_unit] ERROR");
    end
    $finish;
  end

endmodule
